// ----- rtl/rce_pkg.sv -----
// Shared widths, curve codes and types for the reward curve evaluator.
package rce_pkg;

    localparam int SHARE_W = 63;
    localparam int CONST_W = 63;
    localparam int DEN_W   = 65;
    localparam int CLAIM_W = 128;
    localparam int HALF_W  = 64;
    localparam int POS_W   = 6;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_QUAD   = 2'd0;
    localparam t_mode MODE_CURATE = 2'd1;
    localparam t_mode MODE_LINEAR = 2'd2;
    localparam t_mode MODE_SQRT   = 2'd3;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_CONST = 1'b1;

    typedef struct packed {
        t_mode               mode;
        logic                fault;
        logic [CLAIM_W-1:0]  res;
    } t_side;

endpackage

// ----- rtl/rce_mul.sv -----
// Two-stage 63 x 65 bit multiplier built from 32 x 32 partial products.
module rce_mul (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic [rce_pkg::SHARE_W-1:0]   i_a,
    input  logic [rce_pkg::DEN_W-1:0]     i_b,
    output logic [rce_pkg::CLAIM_W-1:0]   o_p
);
    import rce_pkg::*;

    logic [63:0]        r_pp00, r_pp01, r_pp10, r_pp11;
    logic [SHARE_W-1:0] r_top;
    logic [CLAIM_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pp00 <= 64'(i_a[31:0]) * 64'(i_b[31:0]);
            r_pp01 <= 64'(i_a[31:0]) * 64'(i_b[63:32]);
            r_pp10 <= 64'(i_a[62:32]) * 64'(i_b[31:0]);
            r_pp11 <= 64'(i_a[62:32]) * 64'(i_b[63:32]);
            r_top  <= i_b[64] ? i_a : '0;
            r_p    <= CLAIM_W'(r_pp00)
                    + (CLAIM_W'(r_pp01) << 32)
                    + (CLAIM_W'(r_pp10) << 32)
                    + (CLAIM_W'(r_pp11) << 64)
                    + (CLAIM_W'(r_top) << 64);
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/rce_div_step.sv -----
// One registered restoring-division step: one quotient bit per stage.
module rce_div_step #(
    parameter int QW = 65
) (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic [rce_pkg::DEN_W-1:0]   i_rem,
    input  logic                        i_bit,
    input  logic [rce_pkg::DEN_W-1:0]   i_den,
    input  logic [QW-1:0]               i_quo,
    output logic [rce_pkg::DEN_W-1:0]   o_rem,
    output logic [rce_pkg::DEN_W-1:0]   o_den,
    output logic [QW-1:0]               o_quo
);
    import rce_pkg::*;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_take;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [QW-1:0]    r_quo;

    assign w_trial = {i_rem, i_bit};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign w_take  = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // remainder stays below the divisor, so it fits DEN_W bits
            r_rem <= w_take ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_den <= i_den;
            r_quo <= {i_quo[QW-2:0], w_take};
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

// ----- rtl/reward_curve_evaluator.sv -----
// Top level of the reward curve evaluator: curve pipeline and config registers.
//
// Usage: a share count enters on the input channel (i_valid / o_ready) and one
// 128-bit claim leaves on the output channel (o_valid / i_ready) per transaction.
// The curve is picked by curve_mode (register 0): quadratic r*(r+2s), curation
// (r << SHARE_BITS)/(2s+r), linear r, or an approximate square root.
// The per-content constant s sits in register 1. Write registers through
// i_cfg_we, i_cfg_index and i_cfg_data only while no transaction is in flight.
//
// The curation quotient is produced by a chain of SHARE_BITS + 1 restoring-division
// steps, one quotient bit per stage; that chain sets the latency, and the other
// curves travel alongside it on a delay line.
// Throughput: one transaction per cycle while the receiver does not stall.
//
// Reset (synchronous, active low) empties the pipeline and sets both
// registers to 0. When the receiver stalls, the whole pipeline holds; o_ready
// drops only while a finished result waits and the output is not taken.
// A zero curation divisor gives a zero claim with o_divide_fault set.
module reward_curve_evaluator #(
    parameter int SHARE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [rce_pkg::CONST_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rce_pkg::SHARE_W-1:0]   i_share_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rce_pkg::HALF_W-1:0]    o_claim_high,
    output logic [rce_pkg::HALF_W-1:0]    o_claim_low,
    output logic                          o_divide_fault
);
    import rce_pkg::*;

    localparam int QW  = SHARE_BITS + 1;   // quotient never exceeds 2^SHARE_BITS
    localparam int DLY = SHARE_BITS - 1;   // side path stages after stage C

    // configuration
    t_mode              r_curve_mode;
    logic [CONST_W-1:0] r_content;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode <= MODE_QUAD;
            r_content    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_curve_mode <= i_cfg_data[1:0];
                CFG_CONST: r_content    <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // one enable for every stage: advance unless the result register is stuck
    logic w_ce;
    logic r_out_valid;
    assign w_ce    = !r_out_valid || i_ready;
    assign o_ready = w_ce;

    // stage A: capture share, form d = 2s + r
    logic               r_a_valid;
    t_mode              r_a_mode;
    logic [SHARE_W-1:0] r_a_r;
    logic [DEN_W-1:0]   r_a_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ce) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_mode <= r_curve_mode;
            r_a_r    <= i_share_count;
            r_a_d    <= {1'b0, r_content, 1'b0} + DEN_W'(i_share_count);
        end
    end

    // quadratic: (r+s)^2 - s^2 = r * (r + 2s)
    logic [CLAIM_W-1:0] w_prod;

    rce_mul u_mul (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_a   (r_a_r),
        .i_b   (r_a_d),
        .o_p   (w_prod)
    );

    // stage B: leading-one position, zero-divisor flag
    logic               r_b_valid;
    t_mode              r_b_mode;
    logic               r_b_fault;
    logic [SHARE_W-1:0] r_b_r;
    logic [POS_W-1:0]   r_b_pos;
    logic [POS_W-1:0]   w_lead;

    always_comb begin
        w_lead = '0;
        for (int i = 1; i < SHARE_W; i++) begin
            if (r_a_r[i]) w_lead = POS_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_ce) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_b_mode  <= r_a_mode;
            r_b_fault <= (r_a_mode == MODE_CURATE) && (r_a_d == '0);
            r_b_r     <= r_a_r;
            r_b_pos   <= w_lead;
        end
    end

    // stage C: square root approximation or linear value
    logic               r_c_valid;
    t_mode              r_c_mode;
    logic               r_c_fault;
    logic [HALF_W-1:0]  r_c_small;
    logic [POS_W-1:0]   w_half;
    logic [HALF_W-1:0]  w_zbit, w_mant, w_zhi, w_zlo, w_root;

    always_comb begin
        w_half = r_b_pos >> 1;
        w_zbit = HALF_W'(1) << w_half;
        w_mant = HALF_W'(r_b_r) & ((HALF_W'(1) << r_b_pos) - HALF_W'(1));
        w_zhi  = r_b_pos[0] ? w_zbit : '0;
        w_zlo  = w_mant >> (r_b_pos - w_half);
        w_root = (r_b_r == '0) ? '0 : (w_zbit | ((w_zhi | w_zlo) >> 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_ce) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_c_mode  <= r_b_mode;
            r_c_fault <= r_b_fault;
            r_c_small <= (r_b_mode == MODE_SQRT) ? w_root : HALF_W'(r_b_r);
        end
    end

    // side delay line, aligned with the end of the divider chain
    logic  r_dly_valid [DLY];
    t_side r_dly       [DLY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLY; k++) r_dly_valid[k] <= 1'b0;
        end else if (w_ce) begin
            r_dly_valid[0] <= r_c_valid;
            for (int k = 1; k < DLY; k++) r_dly_valid[k] <= r_dly_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_dly[0].mode  <= r_c_mode;
            r_dly[0].fault <= r_c_fault;
            r_dly[0].res   <= (r_c_mode == MODE_QUAD) ? w_prod : CLAIM_W'(r_c_small);
            for (int k = 1; k < DLY; k++) r_dly[k] <= r_dly[k-1];
        end
    end

    // curation divider: remainder starts at r >> 1, numerator bits are r[0]
    // followed by zeros
    logic [DEN_W-1:0] w_rem [QW+1];
    logic [DEN_W-1:0] w_den [QW+1];
    logic [QW-1:0]    w_quo [QW+1];

    assign w_rem[0] = DEN_W'(r_a_r[SHARE_W-1:1]);
    assign w_den[0] = r_a_d;
    assign w_quo[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        rce_div_step #(.QW(QW)) u_step (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_rem (w_rem[k]),
            .i_bit ((k == 0) ? r_a_r[0] : 1'b0),
            .i_den (w_den[k]),
            .i_quo (w_quo[k]),
            .o_rem (w_rem[k+1]),
            .o_den (w_den[k+1]),
            .o_quo (w_quo[k+1])
        );
    end

    // output register
    t_mode              r_out_mode;
    logic               r_out_fault;
    logic [CLAIM_W-1:0] r_out_res;
    t_side              w_last;

    assign w_last = r_dly[DLY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ce) begin
            r_out_valid <= r_dly_valid[DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_mode  <= w_last.mode;
            r_out_fault <= w_last.fault;
            if (w_last.mode != MODE_CURATE) begin
                r_out_res <= w_last.res;
            end else if (w_last.fault) begin
                r_out_res <= '0;
            end else begin
                r_out_res <= CLAIM_W'(w_quo[QW]);
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_claim_high   = r_out_res[CLAIM_W-1:HALF_W];
    assign o_claim_low    = r_out_res[HALF_W-1:0];
    assign o_divide_fault = r_out_fault;

    // a faulted division always reports a zero claim
    a_fault_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_fault |-> o_claim_high == '0 && o_claim_low == '0)
        else $error("divide fault with nonzero claim");

    // only the curation curve can raise the fault
    a_fault_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_fault |-> r_out_mode == MODE_CURATE)
        else $error("divide fault outside curation mode");

    // curation quotient leaves every claim bit above bit 64 clear
    a_quo_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_out_mode == MODE_CURATE |-> o_claim_high[HALF_W-1:1] == '0)
        else $error("curation quotient out of range");

    // square root and linear results fit the low word
    a_low_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_out_mode == MODE_SQRT || r_out_mode == MODE_LINEAR)
        |-> o_claim_high == '0)
        else $error("nonzero high word for a narrow curve");

    // reset empties the pipeline
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule
